FILE: hw/rtl/ps2mct_pkg.sv
// types and constants for the ps/2 mouse cursor tracker
package ps2mct_pkg;

    // screen size registers
    localparam int unsigned SIZE_W = 13;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;

    // header byte fields
    localparam logic [7:0] HDR_SYNC_MASK  = 8'hC0;
    localparam int unsigned HDR_ALWAYS1_BIT = 3;
    localparam int unsigned HDR_MIDDLE_BIT  = 2;
    localparam int unsigned HDR_RIGHT_BIT   = 1;
    localparam int unsigned HDR_LEFT_BIT    = 0;

    // color codes
    localparam logic [1:0] COLOR_NONE   = 2'd0;
    localparam logic [1:0] COLOR_WHITE  = 2'd1;
    localparam logic [1:0] COLOR_RED    = 2'd2;
    localparam logic [1:0] COLOR_BLUE   = 2'd3;

    // place of the next byte within a packet
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } t_byte_pos;

endpackage

FILE: hw/rtl/ps2_mouse_cursor_tracker.sv
// ps/2 mouse packet decoder with clamped cursor tracking
//
// input channel: one raw mouse byte per request (i_in_valid / o_in_ready,
// i_data_byte). bytes are gathered into three-byte packets; while waiting
// for a header, bytes with bit 7 or 6 set or bit 3 clear are dropped.
// output channel: one request per packet (o_out_valid / i_out_ready) with
// the clamped cursor column and row, the button color and the blank flag.
// config channel: i_cfg_valid / o_cfg_ready with index 0 screen width and
// index 1 screen height; always ready, write only while idle.
// the result is registered and shown in the cycle after the third byte is
// accepted. bytes go in at one byte per cycle unless a third byte is held
// back by the single result register behind the add and clamp logic.
// when the receiver stalls, header and x bytes are still taken; the next
// third byte waits until the pending result is taken or is being taken.
// reset (synchronous, active low) sets the cursor to 0,0, the packet
// position to the header and the screen size to 1024 by 768.
module ps2_mouse_cursor_tracker #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COORD_BITS-1:0]         o_cursor_x,
    output logic [COORD_BITS-1:0]         o_cursor_y,
    output logic [1:0]                    o_button_color,
    output logic                          o_glyph_blank,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ps2mct_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ps2mct_pkg::SIZE_W-1:0] i_cfg_data
);
    import ps2mct_pkg::*;

    // working width for sums and limits
    localparam int unsigned CALC_W =
        (COORD_BITS + 2 > SIZE_W + 1) ? COORD_BITS + 2 : SIZE_W + 1;
    localparam logic signed [CALC_W-1:0] COORD_LIMIT =
        CALC_W'(1) << COORD_BITS;

    t_byte_pos r_pos, n_pos;

    logic [SIZE_W-1:0]     r_width, r_height;
    logic [7:0]            r_header, r_x_step;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic                  r_out_valid;
    logic [1:0]            r_color, n_color;
    logic                  r_blank, n_blank;

    logic in_fire;
    logic hdr_ok;
    logic load_header;
    logic load_x;
    logic load_result;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [CALC_W-1:0] v,
        input logic [SIZE_W-1:0]        size
    );
        logic signed [CALC_W-1:0] limit;
        logic signed [CALC_W-1:0] res;
        limit = signed'(CALC_W'(size));
        if (size == '0) begin
            limit = CALC_W'(1);
        end
        if (limit > COORD_LIMIT) begin
            limit = COORD_LIMIT;
        end
        res = v;
        if (res >= limit) begin
            res = limit - CALC_W'(1);
        end
        if (res < 0) begin
            res = '0;
        end
        return res[COORD_BITS-1:0];
    endfunction

    assign hdr_ok = ((i_data_byte & HDR_SYNC_MASK) == 8'h00) && i_data_byte[HDR_ALWAYS1_BIT];

    // a third byte needs the result register free; other bytes go in always
    assign o_in_ready = (r_pos == POS_HEADER) || (r_pos == POS_X)
                        || !r_out_valid || i_out_ready;
    assign in_fire = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // next packet position
    always_comb begin
        n_pos = r_pos;
        if (in_fire) begin
            case (r_pos)
                POS_HEADER: n_pos = hdr_ok ? POS_X : POS_HEADER;
                POS_X:      n_pos = POS_Y;
                default:    n_pos = POS_HEADER;
            endcase
        end
    end

    // load strobes per packet position
    always_comb begin
        load_header = 1'b0;
        load_x      = 1'b0;
        load_result = 1'b0;
        case (r_pos)
            POS_HEADER: load_header = in_fire && hdr_ok;
            POS_X:      load_x      = in_fire;
            default:    load_result = in_fire;
        endcase
    end

    // cursor update and button decode
    always_comb begin
        n_pos_x = clamp_coord(signed'(CALC_W'(r_pos_x))
                              + CALC_W'(signed'(r_x_step)), r_width);
        n_pos_y = clamp_coord(signed'(CALC_W'(r_pos_y))
                              - CALC_W'(signed'(i_data_byte)), r_height);
        if (r_header[HDR_LEFT_BIT]) begin
            n_color = COLOR_BLUE;
        end else if (r_header[HDR_RIGHT_BIT]) begin
            n_color = COLOR_RED;
        end else if (r_header[HDR_MIDDLE_BIT]) begin
            n_color = COLOR_WHITE;
        end else begin
            n_color = COLOR_NONE;
        end
        n_blank = r_header[HDR_LEFT_BIT] | r_header[HDR_RIGHT_BIT]
                  | r_header[HDR_MIDDLE_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HEADER;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
            r_width     <= SCREEN_WIDTH_RESET;
            r_height    <= SCREEN_HEIGHT_RESET;
        end else begin
            r_pos <= n_pos;
            if (load_result) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load_header) begin
            r_header <= i_data_byte;
        end
        if (load_x) begin
            r_x_step <= i_data_byte;
        end
        if (load_result) begin
            r_color <= n_color;
            r_blank <= n_blank;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_x     = r_pos_x;
    assign o_cursor_y     = r_pos_y;
    assign o_button_color = r_color;
    assign o_glyph_blank  = r_blank;

`ifndef SYNTHESIS
    // a new result only follows a third byte
    a_result_from_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_fire && r_pos == POS_Y))
        else $error("result appeared without a third byte");

    // a third byte never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_pos == POS_Y) |-> (!r_out_valid || i_out_ready))
        else $error("third byte accepted over a pending result");

    // blank flag agrees with the color code
    a_blank_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_blank == (r_color != COLOR_NONE)))
        else $error("blank flag and color code disagree");
`endif

endmodule

FILE: bench/ps2mct_checker.sv
// cursor report predictor and scoreboard for the ps/2 mouse cursor tracker
`timescale 1ns / 100ps

module ps2mct_checker #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [COORD_BITS-1:0]              i_cursor_x,
    input  logic [COORD_BITS-1:0]              i_cursor_y,
    input  logic [1:0]                         i_button_color,
    input  logic                               i_glyph_blank,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [ps2mct_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ps2mct_pkg::SIZE_W-1:0]      i_cfg_data,
    output int unsigned                        o_fail_count,
    output int unsigned                        o_pending,
    output int unsigned                        o_report_count
);
    import ps2mct_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [1:0]            color;
        logic                  blank;
    } t_cursor_report;

    t_cursor_report        report_q[$];
    t_cursor_report        exp_rep;
    t_cursor_report        got_rep;

    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    t_byte_pos             byte_pos;
    logic [7:0]            header_reg;
    logic [7:0]            x_step_reg;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;

    int unsigned fail_cnt   = 0;
    int unsigned pending    = 0;
    int unsigned report_cnt = 0;

    assign o_fail_count   = fail_cnt;
    assign o_pending      = pending;
    assign o_report_count = report_cnt;

    // zero counts as one, anything past the coordinate range saturates
    function automatic logic [COORD_BITS-1:0] clamp_axis(input int v,
                                                         input logic [SIZE_W-1:0] size);
        int lim;
        lim = (size == '0) ? 1 : int'(size);
        if (lim > (1 << COORD_BITS))
            lim = 1 << COORD_BITS;
        if (v >= lim)
            v = lim - 1;
        if (v < 0)
            v = 0;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic decode_mouse_byte(input logic [7:0] b);
        t_cursor_report rep;
        case (byte_pos)
            POS_HEADER: begin
                // out-of-sync bytes are dropped without touching state
                if ((b & HDR_SYNC_MASK) == 8'h00 && b[HDR_ALWAYS1_BIT]) begin
                    header_reg = b;
                    byte_pos   = POS_X;
                end
            end
            POS_X: begin
                x_step_reg = b;
                byte_pos   = POS_Y;
            end
            default: begin
                byte_pos = POS_HEADER;
                // sign and overflow header bits play no part in the steps
                cur_x = clamp_axis(int'(cur_x) + int'($signed(x_step_reg)), width_reg);
                cur_y = clamp_axis(int'(cur_y) - int'($signed(b)), height_reg);
                if (header_reg[HDR_LEFT_BIT])
                    rep.color = COLOR_BLUE;
                else if (header_reg[HDR_RIGHT_BIT])
                    rep.color = COLOR_RED;
                else if (header_reg[HDR_MIDDLE_BIT])
                    rep.color = COLOR_WHITE;
                else
                    rep.color = COLOR_NONE;
                rep.blank = header_reg[HDR_LEFT_BIT] | header_reg[HDR_RIGHT_BIT]
                          | header_reg[HDR_MIDDLE_BIT];
                rep.x = cur_x;
                rep.y = cur_y;
                report_q.push_back(rep);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = SCREEN_WIDTH_RESET;
            height_reg = SCREEN_HEIGHT_RESET;
            byte_pos   = POS_HEADER;
            header_reg = 8'h00;
            x_step_reg = 8'h00;
            cur_x      = '0;
            cur_y      = '0;
            report_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  = i_cfg_data;
                    CFG_SCREEN_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            // the oldest report leaves before this edge's third byte adds one
            if (i_out_valid && i_out_ready) begin
                got_rep = '{i_cursor_x, i_cursor_y, i_button_color, i_glyph_blank};
                if (report_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected report x=%0d y=%0d color=%0d blank=%0d",
                             $time, got_rep.x, got_rep.y, got_rep.color, got_rep.blank);
                end else begin
                    exp_rep = report_q.pop_front();
                    report_cnt++;
                    if (got_rep !== exp_rep) begin
                        fail_cnt++;
                        $display("%0t: mismatch expected x=%0d y=%0d color=%0d blank=%0d",
                                 $time, exp_rep.x, exp_rep.y, exp_rep.color, exp_rep.blank);
                        $display("%0t:          actual   x=%0d y=%0d color=%0d blank=%0d",
                                 $time, got_rep.x, got_rep.y, got_rep.color, got_rep.blank);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                decode_mouse_byte(i_data_byte);
        end
        pending = report_q.size();
    end

endmodule

FILE: bench/tb_ps2_mouse_cursor_tracker.sv
// stimulus and verdict for the ps/2 mouse cursor tracker
`timescale 1ns / 100ps

module tb_ps2_mouse_cursor_tracker;
    import ps2mct_pkg::*;

    localparam int unsigned COORD_BITS   = 12;
    localparam int unsigned PACKET_BYTES = 750;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [7:0]             data_byte = 8'h00;
    logic                   out_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
    logic [SIZE_W-1:0]      cfg_data  = '0;

    logic                   in_ready;
    logic                   out_valid;
    logic                   cfg_ready;
    logic [COORD_BITS-1:0]  cursor_x;
    logic [COORD_BITS-1:0]  cursor_y;
    logic [1:0]             button_color;
    logic                   glyph_blank;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned report_count;

    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned pkt_bytes   = 0;
    int unsigned cfg_writes  = 0;
    bit          no_idle     = 1'b0;
    int          x_drift;
    int          y_drift;

    always #1 clk = ~clk;

    ps2_mouse_cursor_tracker #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_cursor_x     (cursor_x),
        .o_cursor_y     (cursor_y),
        .o_button_color (button_color),
        .o_glyph_blank  (glyph_blank),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    ps2mct_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_cursor_x     (cursor_x),
        .i_cursor_y     (cursor_y),
        .i_button_color (button_color),
        .i_glyph_blank  (glyph_blank),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_report_count (report_count)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall before each report, ready stays up when no stall
    initial begin
        int unsigned gap;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // returns at the falling edge after the request is taken, valid still high
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic push_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        push_byte(hdr);
        push_byte(dx);
        push_byte(dy);
    endtask

    // caller lowers cfg_valid after its last write
    task automatic write_screen_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_writes++;
    endtask

    // extremes often, otherwise a step leaning toward the drift direction
    function automatic logic [7:0] rand_step(input int drift);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h7F;
        if (r < 4)
            return 8'h80;
        if (drift > 0)
            return 8'($urandom_range(0, 127));
        if (drift < 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [7:0]        hdr;
        int unsigned       burst;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: dropped headers, step extremes, button priority
        push_byte(8'h80);
        push_byte(8'h40);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_packet(8'h08, 8'h7F, 8'h80);
        push_packet(8'h09, 8'h80, 8'h7F);
        push_packet(8'h0E, 8'h00, 8'h00);
        push_packet(8'h0C, 8'hFF, 8'h01);
        push_packet(8'h3F, 8'h01, 8'hFF);
        push_packet(8'h0A, 8'h0D, 8'hC8);
        push_byte(8'h37);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // idle before touching the size registers
            in_valid <= 1'b0;
            while (pending != 0) @(negedge clk);
            repeat (4) @(negedge clk);
            case (phase)
                0: begin w = 13'd1;    h = 13'd1;    end
                1: begin w = 13'd4096; h = 13'd4096; end
                2: begin w = 13'd0;    h = 13'd8191; end
                3: begin w = 13'd8191; h = 13'd0;    end
                4: begin w = SCREEN_WIDTH_RESET; h = SCREEN_HEIGHT_RESET; end
                5: begin w = 13'($urandom_range(4097, 8191)); h = 13'($urandom_range(1, 64)); end
                default: begin
                    w = 13'($urandom_range(1, 300));
                    h = 13'($urandom_range(1, 4096));
                end
            endcase
            write_screen_reg(CFG_SCREEN_WIDTH, w);
            write_screen_reg(CFG_SCREEN_HEIGHT, h);
            cfg_valid <= 1'b0;

            burst = 0;
            while (pkt_bytes < (phase + 1) * PACKET_BYTES / NUM_PHASES) begin
                if (burst == 0) begin
                    no_idle = ($urandom_range(0, 4) == 0);
                    x_drift = int'($urandom_range(0, 2)) - 1;
                    y_drift = int'($urandom_range(0, 2)) - 1;
                    burst   = 16;
                end
                burst--;
                if ($urandom_range(0, 9) == 0) begin
                    // noise that may or may not pass as a header
                    push_byte(8'($urandom_range(0, 255)));
                end else begin
                    hdr = {2'b00, 2'($urandom_range(0, 3)), 1'b1, 3'($urandom_range(0, 7))};
                    push_packet(hdr, rand_step(x_drift), rand_step(y_drift));
                    pkt_bytes += 3;
                end
            end
        end

        in_valid <= 1'b0;
        no_idle = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d mouse bytes and %0d checked cursor reports",
                 bytes_sent, report_count);
        $display("screen size was rewritten %0d times, from zero through one and 4096 to 8191",
                 cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
